>>> sv/sbf_pkg.sv
package sbf_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 25;

  localparam logic [7:0]  START_BYTE = 8'h0F;
  localparam logic [7:0]  END_BYTE   = 8'h00;
  localparam logic [15:0] GAP_RESET  = 16'd10;

  localparam int unsigned INDEX_W = 5;

  typedef struct packed {
    logic        push;
    logic [31:0] frame_time;
  } cmd_t;

  typedef struct packed {
    logic       we;
    logic [7:0] data;
  } mem_wr_t;

endpackage

>>> sv/sbf_in_if.sv
interface sbf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] rx_time;

  modport source (output valid, output rx_byte, output rx_time, input ready);
  modport sink (input valid, input rx_byte, input rx_time, output ready);
endinterface

>>> sv/sbf_out_if.sv
interface sbf_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  frame_byte;
  logic [sbf_pkg::INDEX_W-1:0] byte_index;
  logic [31:0]                 frame_time;
  logic                        last_in_frame;

  modport source (
    output valid, output frame_byte, output byte_index, output frame_time,
    output last_in_frame, input ready
  );
  modport sink (
    input valid, input frame_byte, input byte_index, input frame_time,
    input last_in_frame, output ready
  );
endinterface

>>> sv/sbf_front.sv
module sbf_front #(
  parameter int unsigned FRAME_BYTES = sbf_pkg::FRAME_BYTES_DEF,
  localparam int unsigned PW = $clog2(FRAME_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             gap_ticks_we_i,
  input  logic [15:0]      gap_ticks_i,
  sbf_in_if.sink           in_i,
  input  logic             q_full_i,
  output sbf_pkg::cmd_t    push_o,
  output sbf_pkg::mem_wr_t wr_o,
  output logic [PW-1:0]    wr_addr_o
);

  localparam logic [PW-1:0] LAST = PW'(FRAME_BYTES - 1);

  logic [15:0]   gap_q;
  logic [PW-1:0] pos_q, pos_d, pos_eff;
  logic [31:0]   last_time_q;
  logic          start_ok_q, start_ok_d;
  logic [31:0]   gap;
  logic          acc, new_frame, emit;

  assign in_i.ready = !q_full_i;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    gap        = in_i.rx_time - last_time_q;
    new_frame  = gap > {16'b0, gap_q};
    pos_eff    = new_frame ? '0 : pos_q;
    pos_d      = (pos_eff == LAST) ? LAST : pos_eff + PW'(1);
    start_ok_d = (pos_eff == '0) ? (in_i.rx_byte == sbf_pkg::START_BYTE) : start_ok_q;
    emit       = acc && (pos_eff == LAST) && start_ok_q
                 && (in_i.rx_byte == sbf_pkg::END_BYTE);
  end

  assign push_o.push       = emit;
  assign push_o.frame_time = in_i.rx_time;
  assign wr_o.we           = acc;
  assign wr_o.data         = in_i.rx_byte;
  assign wr_addr_o         = pos_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q       <= sbf_pkg::GAP_RESET;
      pos_q       <= '0;
      last_time_q <= '0;
      start_ok_q  <= 1'b0;
    end else begin
      if (gap_ticks_we_i) begin
        gap_q <= gap_ticks_i;
      end
      if (acc) begin
        pos_q       <= pos_d;
        last_time_q <= in_i.rx_time;
        start_ok_q  <= start_ok_d;
      end
    end
  end

endmodule

>>> sv/sbf_cmd_queue.sv
module sbf_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sbf_pkg::cmd_t push_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [31:0]   frame_time_o
);

  logic        valid_q;
  logic [31:0] time_q;

  assign valid_o      = valid_q;
  assign frame_time_o = time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i.push) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      time_q <= push_i.frame_time;
    end
  end

endmodule

>>> sv/sbf_back.sv
module sbf_back #(
  parameter int unsigned FRAME_BYTES = sbf_pkg::FRAME_BYTES_DEF,
  localparam int unsigned PW = $clog2(FRAME_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sbf_pkg::mem_wr_t wr_i,
  input  logic [PW-1:0]    wr_addr_i,
  input  logic             q_valid_i,
  input  logic [31:0]      q_time_i,
  output logic             pop_o,
  sbf_out_if.source        out_o
);

  localparam logic [PW-1:0] LAST = PW'(FRAME_BYTES - 1);

  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    rdata_q;
  logic [PW-1:0] cnt_q;
  logic          s1_v_q, s1_last_q;
  logic [PW-1:0] s1_idx_q;
  logic [31:0]   s1_time_q;
  logic          out_v_q, out_last_q;
  logic [PW-1:0] out_idx_q;
  logic [31:0]   out_time_q;
  logic [7:0]    out_byte_q;
  logic          advance, s1_free, rd_en;

  assign advance = !out_v_q || out_o.ready;
  assign s1_free = !s1_v_q || advance;
  assign rd_en   = q_valid_i && s1_free;
  assign pop_o   = rd_en && (cnt_q == LAST);

  assign out_o.valid         = out_v_q;
  assign out_o.frame_byte    = out_byte_q;
  assign out_o.byte_index    = sbf_pkg::INDEX_W'(out_idx_q);
  assign out_o.frame_time    = out_time_q;
  assign out_o.last_in_frame = out_last_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_addr_i] <= wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rd_en) begin
        cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + PW'(1);
      end
      if (s1_free) begin
        s1_v_q <= rd_en;
      end
      if (advance) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_idx_q  <= cnt_q;
      s1_last_q <= cnt_q == LAST;
      s1_time_q <= q_time_i;
    end
    if (advance && s1_v_q) begin
      out_byte_q <= rdata_q;
      out_idx_q  <= s1_idx_q;
      out_last_q <= s1_last_q;
      out_time_q <= s1_time_q;
    end
  end

  a_cnt_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> q_valid_i)
    else $error("read counter moved outside a frame");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_last_q |-> out_idx_q == LAST)
    else $error("last marker on wrong byte");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !advance |=> s1_v_q && $stable(s1_idx_q) && $stable(rdata_q))
    else $error("stalled read stage lost its item");

endmodule

>>> sv/sbus_frame_receiver.sv
// Serial control frame receiver.
// in_i carries received bytes (rx_byte) with their tick time (rx_time);
// gap_ticks_we_i/gap_ticks_i write the inter-byte gap threshold (reset 10).
// A gap above the threshold restarts the frame at slot 0; once the last slot
// is reached every further byte overwrites it. When a byte lands in the last
// slot, slot 0 holds 0x0F and that byte is 0x00, out_o streams the whole
// frame, slot 0 first, with the completing byte's time and a last marker.
// A byte that completes no frame is taken whenever in_i.ready is high, back to back.
// A completing byte queues one frame command; the first result passes the
// command queue, the memory read stage and the output register, then one per
// cycle while out_o.ready is high, FRAME_BYTES results in all, set by the
// single read port of the frame memory. in_i.ready stays low from the cycle
// after the completing byte until the last slot has been read, later if out_o
// stalls. A stalled out_o holds its item and the two-stage read pipe behind
// it; bytes that arrive after the last read are taken while the remaining
// results drain.
// Reset clears the write position, last byte time, command queue and output
// valid, and restores the gap threshold; the frame memory is not cleared.
module sbus_frame_receiver #(
  parameter int unsigned FRAME_BYTES = sbf_pkg::FRAME_BYTES_DEF,
  localparam int unsigned PW = $clog2(FRAME_BYTES)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        gap_ticks_we_i,
  input  logic [15:0] gap_ticks_i,
  sbf_in_if.sink      in_i,
  sbf_out_if.source   out_o
);

  sbf_pkg::cmd_t    push;
  sbf_pkg::mem_wr_t wr;
  logic [PW-1:0]    wr_addr;
  logic             q_valid, pop;
  logic [31:0]      q_time;

  sbf_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .gap_ticks_we_i (gap_ticks_we_i),
    .gap_ticks_i    (gap_ticks_i),
    .in_i           (in_i),
    .q_full_i       (q_valid),
    .push_o         (push),
    .wr_o           (wr),
    .wr_addr_o      (wr_addr)
  );

  sbf_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .frame_time_o (q_time)
  );

  sbf_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .q_valid_i (q_valid),
    .q_time_i  (q_time),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

>>> sim/tb_top.sv
module tb_top;

  localparam int unsigned NBYTES = sbf_pkg::FRAME_BYTES_DEF;
  localparam int unsigned LAST_SLOT = NBYTES - 1;

  typedef struct {
    logic [7:0]                  data;
    logic [sbf_pkg::INDEX_W-1:0] idx;
    logic [31:0]                 stamp;
    logic                        last;
  } frame_beat_t;

  typedef enum {READY_FREE, READY_RANDOM, READY_PATTERN} ready_style_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        gap_ticks_we_i;
  logic [15:0] gap_ticks_i;

  sbf_in_if  in_if ();
  sbf_out_if out_if ();

  sbus_frame_receiver u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .gap_ticks_we_i (gap_ticks_we_i),
    .gap_ticks_i    (gap_ticks_i),
    .in_i           (in_if),
    .out_o          (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0]                  rx_image [NBYTES];
  logic [sbf_pkg::INDEX_W-1:0] slot_next;
  logic [31:0]                 prev_stamp;
  logic [15:0]                 gap_limit;
  frame_beat_t                 pending_beats [$];

  int           mismatches;
  int           bytes_sent;
  int           beats_seen;
  int           frames_seen;
  int           hold_left;
  int           burst_left;
  bit           sender_gaps;
  ready_style_e ready_style;
  logic [6:0]   ready_pattern = 7'b1011011;

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic [31:0] t);
    logic [31:0] delta;
    frame_beat_t beat;
    delta = t - prev_stamp;
    prev_stamp = t;
    if (delta > {16'h0000, gap_limit}) slot_next = '0;
    rx_image[slot_next] = b;
    if (slot_next < LAST_SLOT) begin
      slot_next++;
    end else if (rx_image[0] == sbf_pkg::START_BYTE &&
                 rx_image[LAST_SLOT] == sbf_pkg::END_BYTE) begin
      for (int k = 0; k < NBYTES; k++) begin
        beat.data  = rx_image[k];
        beat.idx   = sbf_pkg::INDEX_W'(k);
        beat.stamp = t;
        beat.last  = (k == LAST_SLOT);
        pending_beats.push_back(beat);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
    int idle;
    if (sender_gaps && burst_left <= 0) begin
      idle = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 30);
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    in_if.rx_time <= t;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_byte(b, t);
    bytes_sent++;
  endtask

  task automatic drain_frames();
    in_if.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_gap_threshold(input logic [15:0] value);
    drain_frames();
    gap_ticks_i    <= value;
    gap_ticks_we_i <= 1'b1;
    @(posedge clk_i);
    gap_ticks_we_i <= 1'b0;
    gap_limit = value;
  endtask

  // Open with a gap above the threshold so the frame starts at slot 0.
  task automatic send_frame(input bit good_start, input bit good_end,
                            input int cut_at, input int tail);
    logic [31:0] t;
    logic [7:0]  b;
    int          n;
    n = (cut_at > 0) ? cut_at : NBYTES + tail;
    t = prev_stamp + 32'(gap_limit) + 32'd1 + 32'($urandom_range(0, 5000));
    for (int k = 0; k < n; k++) begin
      if (k > 0) t = t + 32'($urandom_range(0, gap_limit));
      b = 8'($urandom);
      if (k == 0) begin
        if (good_start) b = sbf_pkg::START_BYTE;
        else if (b == sbf_pkg::START_BYTE) b = ~b;
      end else if (k == LAST_SLOT) begin
        if (good_end) b = sbf_pkg::END_BYTE;
        else if (b == sbf_pkg::END_BYTE) b = 8'h5A;
      end else if (k > LAST_SLOT && $urandom_range(0, 1) == 1) begin
        b = sbf_pkg::END_BYTE;
      end
      send_byte(b, t);
    end
  endtask

  task automatic send_noise(input int n);
    logic [31:0] t;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 1) == 1) t = prev_stamp + 32'($urandom_range(0, gap_limit));
      else t = $urandom;
      send_byte(8'($urandom), t);
    end
  endtask

  task automatic test_wrapping_frame();
    logic [7:0] b;
    logic [31:0] t;
    logic [7:0] corner [7] = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE};
    ready_style = READY_FREE;
    sender_gaps = 1'b0;
    // Spacing equals the threshold, so the time wrap must not restart the frame.
    t = 32'hFFFF_FFEB;
    for (int k = 0; k < NBYTES + 2; k++) begin
      if (k == 0) b = sbf_pkg::START_BYTE;
      else if (k == LAST_SLOT || k == NBYTES) b = sbf_pkg::END_BYTE;
      else if (k == NBYTES + 1) b = 8'h3C;
      else if (k < 7) b = corner[k];
      else b = 8'(k * 37 + 3);
      send_byte(b, t);
      t = t + 32'd10;
    end
    drain_frames();
  endtask

  task automatic test_bad_markers();
    ready_style = READY_PATTERN;
    sender_gaps = 1'b1;
    send_frame(1'b0, 1'b1, 0, 1);
    send_frame(1'b1, 1'b0, 0, 1);
    drain_frames();
  endtask

  task automatic test_gap_extremes();
    ready_style = READY_RANDOM;
    set_gap_threshold(16'h0000);
    send_frame(1'b1, 1'b1, 0, 2);
    send_noise(8);
    set_gap_threshold(16'hFFFF);
    ready_style = READY_PATTERN;
    send_frame(1'b1, 1'b1, 0, 1);
    send_noise(8);
    drain_frames();
  endtask

  task automatic test_backpressure();
    ready_style = READY_FREE;
    sender_gaps = 1'b0;
    hold_left = 300;
    send_frame(1'b1, 1'b1, 0, 12);
    drain_frames();
  endtask

  task automatic test_random_traffic();
    set_gap_threshold(16'($urandom));
    for (int f = 0; f < 3; f++) begin
      if (f == 2) set_gap_threshold(16'($urandom_range(1, 2000)));
      ready_style = ready_style_e'(f % 3);
      sender_gaps = (f != 1);
      if ($urandom_range(0, 4) == 0)
        send_frame(1'b1, 1'b1, $urandom_range(1, LAST_SLOT), 0);
      send_frame($urandom_range(0, 6) != 0, $urandom_range(0, 4) != 0, 0,
                 $urandom_range(0, 3));
      send_noise($urandom_range(2, 6));
    end
    drain_frames();
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      case (ready_style)
        READY_FREE: begin
          out_if.ready <= 1'b1;
        end
        READY_RANDOM: begin
          out_if.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_if.ready <= ready_pattern[6];
          ready_pattern <= {ready_pattern[5:0], ready_pattern[6]};
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    frame_beat_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_beats.size() == 0) begin
        flag_error($sformatf("unexpected item: byte %02h index %0d",
                             out_if.frame_byte, out_if.byte_index));
      end else begin
        want = pending_beats.pop_front();
        beats_seen++;
        if (want.last) frames_seen++;
        if (out_if.frame_byte !== want.data)
          flag_error($sformatf("frame_byte at %0d: expected %02h, got %02h",
                               want.idx, want.data, out_if.frame_byte));
        if (out_if.byte_index !== want.idx)
          flag_error($sformatf("byte_index: expected %0d, got %0d",
                               want.idx, out_if.byte_index));
        if (out_if.frame_time !== want.stamp)
          flag_error($sformatf("frame_time at %0d: expected %08h, got %08h",
                               want.idx, want.stamp, out_if.frame_time));
        if (out_if.last_in_frame !== want.last)
          flag_error($sformatf("last_in_frame at %0d: expected %0b, got %0b",
                               want.idx, want.last, out_if.last_in_frame));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d items outstanding", pending_beats.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.rx_byte  = '0;
    in_if.rx_time  = '0;
    out_if.ready   = 1'b0;
    gap_ticks_we_i = 1'b0;
    gap_ticks_i    = '0;
    rx_image       = '{default: 8'h00};
    slot_next      = '0;
    prev_stamp     = '0;
    gap_limit      = sbf_pkg::GAP_RESET;
    mismatches     = 0;
    bytes_sent     = 0;
    beats_seen     = 0;
    frames_seen    = 0;
    hold_left      = 0;
    burst_left     = 0;
    sender_gaps    = 1'b0;
    ready_style    = READY_FREE;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_wrapping_frame();
    test_bad_markers();
    test_gap_extremes();
    test_backpressure();
    test_random_traffic();

    $display("%0d bytes sent; %0d frames (%0d items) checked", bytes_sent, frames_seen,
             beats_seen);
    $display("gap thresholds 10, 0, 65535, random; time wrap, overwrite, bad markers, hold-off");
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sbf_pkg.sv
sv/sbf_in_if.sv
sv/sbf_out_if.sv
sv/sbf_front.sv
sv/sbf_cmd_queue.sv
sv/sbf_back.sv
sv/sbus_frame_receiver.sv
sim/tb_top.sv
